>>> design/merge_two_sorted_streams_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-way sorted merge
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef MERGE_TWO_SORTED_STREAMS_MACROS_SVH
`define MERGE_TWO_SORTED_STREAMS_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset
`define MTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define MTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MTS_ASSERT(lbl, clk, rst, prop, msg)
`define MTS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> design/mts_pkg.sv
// ----------------------------------------------------------------------------
// Two-way sorted merge package
// Request and response types, function and status codes, sequencer states.
// ----------------------------------------------------------------------------
package mts_pkg;

   // Element width, fixed by the request and response formats
   localparam int unsigned DATA_WIDTH = 16;

   // Request function codes
   localparam logic [1:0] FUNC_PUSH     = 2'd0;
   localparam logic [1:0] FUNC_PUSH_END = 2'd1;
   localparam logic [1:0] FUNC_END      = 2'd2;
   localparam logic [1:0] FUNC_RSVD     = 2'd3;

   // Response status codes
   localparam logic [1:0] STATUS_ELEMENT    = 2'd0;
   localparam logic [1:0] STATUS_DROP_FULL  = 2'd1;
   localparam logic [1:0] STATUS_DROP_ENDED = 2'd2;

   // Source codes
   localparam logic SRC_A = 1'b0;
   localparam logic SRC_B = 1'b1;

   typedef struct packed {
      logic [1:0]            func;
      logic                  source;
      logic [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] out_value;
      logic                  from_source;
      logic [1:0]            status;
      logic                  run_last;
      logic                  merge_done;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_PICK
   } state_type;

endpackage

>>> design/mts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mts_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/merge_two_sorted_streams.sv
// ----------------------------------------------------------------------------
// Two-way sorted merge
// Merges ascending streams A and B, buffered in two RAMs, into one stream.
// ----------------------------------------------------------------------------
// A request that causes no element leaves the sequencer idle; a drop
// response is loaded into the response register as the request is taken.
// Each merged element then passes through ST_READ, which reads both buffer
// heads from the RAMs (registered read), and ST_PICK, which compares them,
// loads the response register and advances the head; ST_PICK waits while
// the response channel stalls. New requests are taken only while the
// sequencer is idle and the response register is empty or being emptied in
// the same cycle, so a waiting response holds off every request. Each buffer
// holds DEPTH elements; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "merge_two_sorted_streams_macros.svh"

module merge_two_sorted_streams #(
   parameter int unsigned DEPTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  mts_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output mts_pkg::rsp_type rsp_data
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned DW    = mts_pkg::DATA_WIDTH;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Per-source control state, index 0 is A and 1 is B
   cnt_type cnt_ff   [2];
   cnt_type cnt_in   [2];
   ptr_type head_ff  [2];
   ptr_type head_in  [2];
   ptr_type tail_ff  [2];
   ptr_type tail_in  [2];
   logic    ended_ff [2];
   logic    ended_in [2];

   mts_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mts_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          slot_free;
   logic          is_push, is_end, src;
   logic          drop_ended, drop_full, push_ok;
   cnt_type       acc_cnt   [2];
   logic          acc_ended [2];
   logic          acc_emit, acc_done;
   logic [DW-1:0] head_data [2];
   logic          pick;
   cnt_type       pop_cnt [2];
   logic          pop_emit, pop_done;
   logic          wr_en [2];

   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   // True while the merge order of the next element is settled
   function automatic logic can_emit(input cnt_type ca, input cnt_type cb,
                                     input logic ea, input logic eb);
      logic r;
      r = ((ca != '0) && (cb != '0)) || ((ca != '0) && eb) || ((cb != '0) && ea);
      return r;
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == mts_pkg::ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   // Decode the request against the current buffer state
   always_comb begin
      src        = req_data.source;
      is_push    = (req_data.func == mts_pkg::FUNC_PUSH) ||
                   (req_data.func == mts_pkg::FUNC_PUSH_END);
      is_end     = (req_data.func == mts_pkg::FUNC_PUSH_END) ||
                   (req_data.func == mts_pkg::FUNC_END);
      drop_ended = is_push && ended_ff[src];
      drop_full  = is_push && !ended_ff[src] && (cnt_ff[src] == cnt_type'(DEPTH));
      push_ok    = is_push && !drop_ended && !drop_full;
      for (int s = 0; s < 2; s++) begin
         acc_cnt[s]   = cnt_ff[s];
         acc_ended[s] = ended_ff[s];
      end
      acc_cnt[src]   = cnt_ff[src] + cnt_type'(push_ok);
      acc_ended[src] = ended_ff[src] || is_end;
      acc_emit = can_emit(acc_cnt[0], acc_cnt[1], acc_ended[0], acc_ended[1]);
      acc_done = acc_ended[0] && acc_ended[1] && (acc_cnt[0] == '0) && (acc_cnt[1] == '0);
   end

   // Choose the smaller head, ties to A, and look one pop ahead
   always_comb begin
      if ((cnt_ff[0] != '0) && (cnt_ff[1] != '0)) begin
         pick = (head_data[0] > head_data[1]) ? mts_pkg::SRC_B : mts_pkg::SRC_A;
      end else begin
         pick = (cnt_ff[0] == '0) ? mts_pkg::SRC_B : mts_pkg::SRC_A;
      end
      for (int s = 0; s < 2; s++) begin
         pop_cnt[s] = cnt_ff[s];
      end
      pop_cnt[pick] = cnt_ff[pick] - cnt_type'(1);
      pop_emit = can_emit(pop_cnt[0], pop_cnt[1], ended_ff[0], ended_ff[1]);
      pop_done = ended_ff[0] && ended_ff[1] && (pop_cnt[0] == '0) && (pop_cnt[1] == '0);
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mts_pkg::ST_IDLE: begin
            if (accept && acc_emit) begin
               state_in = mts_pkg::ST_READ;
            end
         end
         mts_pkg::ST_READ: begin
            state_in = mts_pkg::ST_PICK;
         end
         mts_pkg::ST_PICK: begin
            if (slot_free) begin
               state_in = pop_emit ? mts_pkg::ST_READ : mts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mts_pkg::ST_IDLE;
         end
      endcase
   end

   // Buffer pointers, counts and response register updates
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         cnt_in[s]   = cnt_ff[s];
         head_in[s]  = head_ff[s];
         tail_in[s]  = tail_ff[s];
         ended_in[s] = ended_ff[s];
         wr_en[s]    = 1'b0;
      end
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         mts_pkg::ST_IDLE: begin
            if (accept) begin
               for (int s = 0; s < 2; s++) begin
                  cnt_in[s]   = acc_cnt[s];
                  ended_in[s] = acc_ended[s];
               end
               wr_en[src] = push_ok;
               if (push_ok) begin
                  tail_in[src] = ptr_next(tail_ff[src]);
               end
               // Report a dropped push ahead of any elements
               if (drop_ended || drop_full) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.out_value   = '0;
                  rsp_data_in.from_source = src;
                  rsp_data_in.status      = drop_ended ? mts_pkg::STATUS_DROP_ENDED
                                                       : mts_pkg::STATUS_DROP_FULL;
                  rsp_data_in.run_last    = !acc_emit;
                  rsp_data_in.merge_done  = 1'b0;
               end
               // Both sources ended with nothing left: ready for a new merge
               if (acc_done) begin
                  for (int s = 0; s < 2; s++) begin
                     ended_in[s] = 1'b0;
                     head_in[s]  = '0;
                     tail_in[s]  = '0;
                  end
               end
            end
         end
         mts_pkg::ST_READ: begin
         end
         mts_pkg::ST_PICK: begin
            if (slot_free) begin
               for (int s = 0; s < 2; s++) begin
                  cnt_in[s] = pop_cnt[s];
               end
               head_in[pick]           = ptr_next(head_ff[pick]);
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_value   = head_data[pick];
               rsp_data_in.from_source = pick;
               rsp_data_in.status      = mts_pkg::STATUS_ELEMENT;
               rsp_data_in.run_last    = !pop_emit;
               rsp_data_in.merge_done  = pop_done;
               if (pop_done) begin
                  for (int s = 0; s < 2; s++) begin
                     ended_in[s] = 1'b0;
                     head_in[s]  = '0;
                     tail_in[s]  = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < 2; s++) begin
            cnt_ff[s]   <= '0;
            head_ff[s]  <= '0;
            tail_ff[s]  <= '0;
            ended_ff[s] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int s = 0; s < 2; s++) begin
            cnt_ff[s]   <= cnt_in[s];
            head_ff[s]  <= head_in[s];
            tail_ff[s]  <= tail_in[s];
            ended_ff[s] <= ended_in[s];
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // One buffer RAM per source, read at the head pointer
   for (genvar g = 0; g < 2; g++) begin : g_buf
      mts_ram #(
         .WIDTH (DW),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (tail_ff[g]),
         .wr_data (req_data.value),
         .rd_addr (head_ff[g]),
         .rd_data (head_data[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `MTS_ASSERT(a_cnt_bound, clock, reset,
      (cnt_ff[0] <= cnt_type'(DEPTH)) && (cnt_ff[1] <= cnt_type'(DEPTH)),
      "buffer count exceeds depth")
   `MTS_ASSERT(a_idle_settled, clock, reset,
      (state_ff == mts_pkg::ST_IDLE) |->
         !can_emit(cnt_ff[0], cnt_ff[1], ended_ff[0], ended_ff[1]),
      "idle with elements still to emit")
   `MTS_ASSERT(a_pick_nonempty, clock, reset,
      (state_ff == mts_pkg::ST_PICK) |-> ((cnt_ff[0] != '0) || (cnt_ff[1] != '0)),
      "pick with both buffers empty")
   `MTS_ASSERT(a_drop_not_done, clock, reset,
      (rsp_valid && (rsp_data.status != mts_pkg::STATUS_ELEMENT)) |-> !rsp_data.merge_done,
      "drop response marked as merge end")

endmodule

>>> test/tb_merge_two_sorted_streams.sv
// ----------------------------------------------------------------------------
// Two-way sorted merge testbench
// Sends directed and random requests to both streams, predicts every merged
// element and drop response, and checks each response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_merge_two_sorted_streams;

   localparam int unsigned DW          = mts_pkg::DATA_WIDTH;
   localparam int unsigned DEPTH       = 32;
   localparam int unsigned MAX_RESULTS = 64;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned TAIL_CYCLES = 8;
   localparam int unsigned IDLE_PCT    = 10;
   localparam int unsigned RANDOM_REQS = 100;

   // Predicts the merged stream and checks responses against it
   class merge_scoreboard;
      logic [DW-1:0]    store [2][DEPTH];
      int unsigned      fill [2];
      int unsigned      head [2];
      int unsigned      tail [2];
      bit               ended [2];
      mts_pkg::rsp_type merged_q [$];
      int unsigned      errors;

      function new();
         for (int s = 0; s < 2; s++) begin
            fill[s]  = 0;
            head[s]  = 0;
            tail[s]  = 0;
            ended[s] = 1'b0;
         end
         errors = 0;
      endfunction

      function int pending();
         return merged_q.size();
      endfunction

      // Apply one accepted request and queue the responses it causes
      function void note_request(mts_pkg::req_type r);
         mts_pkg::rsp_type held;
         mts_pkg::rsp_type item;
         bit               have_held;
         int               s;
         int               pick;
         int               n;
         s         = r.source;
         n         = 0;
         have_held = 1'b0;
         held      = '0;
         if (r.func == mts_pkg::FUNC_RSVD)
            return;

         // Store the value, or drop it with a status
         if (r.func == mts_pkg::FUNC_PUSH || r.func == mts_pkg::FUNC_PUSH_END) begin
            if (ended[s] || fill[s] >= DEPTH) begin
               held             = '0;
               held.from_source = r.source;
               held.status      = ended[s] ? mts_pkg::STATUS_DROP_ENDED
                                           : mts_pkg::STATUS_DROP_FULL;
               have_held        = 1'b1;
               n++;
            end else begin
               store[s][tail[s]] = r.value;
               tail[s]           = (tail[s] + 1) % DEPTH;
               fill[s]++;
            end
         end
         if (r.func == mts_pkg::FUNC_PUSH_END || r.func == mts_pkg::FUNC_END)
            ended[s] = 1'b1;

         // Emit heads while the order is certain; ties go to A
         while (n < MAX_RESULTS) begin
            if (fill[0] > 0 && fill[1] > 0)
               pick = (store[0][head[0]] <= store[1][head[1]]) ? 0 : 1;
            else if (fill[0] > 0 && ended[1])
               pick = 0;
            else if (fill[1] > 0 && ended[0])
               pick = 1;
            else
               break;
            item             = '0;
            item.out_value   = store[pick][head[pick]];
            item.from_source = (pick == 1);
            item.status      = mts_pkg::STATUS_ELEMENT;
            head[pick]       = (head[pick] + 1) % DEPTH;
            fill[pick]--;
            item.merge_done  = ended[0] && ended[1] && fill[0] == 0 && fill[1] == 0;
            if (have_held)
               merged_q.push_back(held);
            held      = item;
            have_held = 1'b1;
            n++;
         end

         // Clear for a new merge once both streams have ended and drained
         if (ended[0] && ended[1] && fill[0] == 0 && fill[1] == 0) begin
            for (int k = 0; k < 2; k++) begin
               ended[k] = 1'b0;
               head[k]  = 0;
               tail[k]  = 0;
            end
         end

         // Mark the last response of this request
         if (have_held) begin
            held.run_last = 1'b1;
            merged_q.push_back(held);
         end
      endfunction

      function void compare_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      endfunction

      // Check one accepted response against the oldest prediction
      function void check_response(mts_pkg::rsp_type got);
         mts_pkg::rsp_type want;
         if (merged_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual %h", $time, got);
            return;
         end
         want = merged_q.pop_front();
         compare_field("out_value", want.out_value, got.out_value);
         compare_field("from_source", DW'(want.from_source), DW'(got.from_source));
         compare_field("status", DW'(want.status), DW'(got.status));
         compare_field("run_last", DW'(want.run_last), DW'(got.run_last));
         compare_field("merge_done", DW'(want.merge_done), DW'(got.merge_done));
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   mts_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   mts_pkg::rsp_type rsp_data;

   merge_scoreboard sb;
   bit              calm;
   int unsigned     sent_count;
   int unsigned     cycle_count;

   merge_two_sorted_streams u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Stall the response channel at random, except in calm stretches
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("merge_two_sorted_streams regression: fail");
         $finish;
      end
   end

   // Send one request, with an occasional idle gap before it
   task automatic send_request(input logic [1:0] func, input logic source,
                               input logic [DW-1:0] value);
      mts_pkg::req_type r;
      r.func   = func;
      r.source = source;
      r.value  = value;
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      if (func != mts_pkg::FUNC_RSVD)
         sent_count++;
   endtask

   // Hold off the sender until every predicted response has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // One merge: sorted values for each stream, interleaved at random
   task automatic run_merge(input int len_a, input int len_b, input bit noisy);
      logic [DW-1:0] vals [2][$];
      logic [DW-1:0] v;
      bit            open [2];
      bit            narrow;
      int            base;
      int            s;
      narrow = ($urandom_range(0, 3) == 0);
      base   = $urandom_range(0, 65535 - 7);
      for (int i = 0; i < len_a + len_b; i++) begin
         v = narrow ? DW'(base + $urandom_range(0, 7)) : DW'($urandom);
         if (i < len_a)
            vals[0].push_back(v);
         else
            vals[1].push_back(v);
      end
      vals[0].sort();
      vals[1].sort();
      open[0] = 1'b1;
      open[1] = 1'b1;
      while (open[0] || open[1]) begin
         // Inject an arbitrary request now and then
         if (noisy && $urandom_range(0, 99) < 8)
            send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         DW'($urandom));
         if (open[0] && open[1])
            s = $urandom_range(0, 1);
         else
            s = open[1] ? 1 : 0;
         if (vals[s].size() == 0) begin
            send_request(mts_pkg::FUNC_END, s[0], DW'($urandom));
            open[s] = 1'b0;
         end else begin
            v = vals[s].pop_front();
            if (vals[s].size() == 0 && $urandom_range(0, 1)) begin
               send_request(mts_pkg::FUNC_PUSH_END, s[0], v);
               open[s] = 1'b0;
            end else begin
               send_request(mts_pkg::FUNC_PUSH, s[0], v);
            end
         end
      end
   endtask

   // Overfill one stream, end it while full, then drain through the other
   task automatic fill_buffer(input logic source);
      send_request(mts_pkg::FUNC_END, mts_pkg::SRC_A, DW'($urandom));
      send_request(mts_pkg::FUNC_END, mts_pkg::SRC_B, DW'($urandom));
      for (int i = 0; i <= DEPTH; i++)
         send_request(mts_pkg::FUNC_PUSH, source, DW'(i * 1000 + $urandom_range(0, 999)));
      send_request(mts_pkg::FUNC_PUSH_END, source, DW'($urandom));
      send_request(mts_pkg::FUNC_PUSH_END, ~source, DW'($urandom));
   endtask

   initial begin
      int unsigned base_count;
      bit          b_filled;
      sb          = new();
      calm        = 1'b0;
      sent_count  = 0;
      cycle_count = 0;
      b_filled    = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes, ties, drops after end, ignored codes, empty completion
      send_request(mts_pkg::FUNC_PUSH, mts_pkg::SRC_A, 16'h0000);
      send_request(mts_pkg::FUNC_PUSH, mts_pkg::SRC_B, 16'hFFFF);
      send_request(mts_pkg::FUNC_PUSH, mts_pkg::SRC_A, 16'hFFFF);
      send_request(mts_pkg::FUNC_PUSH_END, mts_pkg::SRC_A, 16'hFFFF);
      send_request(mts_pkg::FUNC_PUSH, mts_pkg::SRC_A, 16'h0005);
      send_request(mts_pkg::FUNC_PUSH_END, mts_pkg::SRC_A, 16'h0007);
      send_request(mts_pkg::FUNC_END, mts_pkg::SRC_A, 16'h1234);
      send_request(mts_pkg::FUNC_RSVD, mts_pkg::SRC_B, 16'h1234);
      send_request(mts_pkg::FUNC_PUSH, mts_pkg::SRC_B, 16'h8000);
      send_request(mts_pkg::FUNC_END, mts_pkg::SRC_B, 16'hFFFF);
      send_request(mts_pkg::FUNC_END, mts_pkg::SRC_A, 16'h0000);
      send_request(mts_pkg::FUNC_END, mts_pkg::SRC_B, 16'h0000);
      send_request(mts_pkg::FUNC_PUSH, mts_pkg::SRC_B, 16'h00FF);
      send_request(mts_pkg::FUNC_PUSH, mts_pkg::SRC_B, 16'hAAAA);
      send_request(mts_pkg::FUNC_PUSH_END, mts_pkg::SRC_A, 16'h5555);
      send_request(mts_pkg::FUNC_PUSH_END, mts_pkg::SRC_B, 16'hFF00);
      send_request(mts_pkg::FUNC_RSVD, mts_pkg::SRC_A, 16'h0000);
      send_request(mts_pkg::FUNC_PUSH, mts_pkg::SRC_A, 16'h0001);
      send_request(mts_pkg::FUNC_PUSH, mts_pkg::SRC_B, 16'h0001);
      send_request(mts_pkg::FUNC_END, mts_pkg::SRC_B, 16'hAAAA);
      send_request(mts_pkg::FUNC_END, mts_pkg::SRC_A, 16'h5555);
      wait_drained();

      // Random merges, with one overfill per stream
      base_count = sent_count;
      calm = 1'b1;
      fill_buffer(mts_pkg::SRC_A);
      calm = 1'b0;
      while (sent_count - base_count < RANDOM_REQS) begin
         run_merge($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 3) == 0);
         if (!b_filled && sent_count - base_count >= RANDOM_REQS / 2) begin
            fill_buffer(mts_pkg::SRC_B);
            b_filled = 1'b1;
         end
         if ($urandom_range(0, 99) < 15)
            wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("merge_two_sorted_streams regression: pass");
      else
         $display("merge_two_sorted_streams regression: fail");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/mts_pkg.sv
design/mts_ram.sv
design/merge_two_sorted_streams.sv
test/tb_merge_two_sorted_streams.sv
